// ===== hdl/lbr_pkg.sv =====
package lbr_pkg;

	typedef struct packed {
		logic       kind;
		logic [8:0] col;
		logic [8:0] row;
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic [7:0] alpha;
	} in_item_t;

	typedef struct packed {
		logic [7:0] byte0;
		logic [7:0] byte1;
		logic [7:0] byte2;
		logic [7:0] byte3;
		logic       inside_res;
	} out_item_t;

	typedef struct packed {
		logic [9:0] width;
		logic [9:0] height;
		logic       grey;
		logic       normal;
	} cfg_t;

	localparam logic KIND_LOAD = 1'b0;
	localparam logic KIND_REQ  = 1'b1;

	localparam logic [1:0] REG_SRC_W  = 2'd0;
	localparam logic [1:0] REG_SRC_H  = 2'd1;
	localparam logic [1:0] REG_GREY   = 2'd2;
	localparam logic [1:0] REG_NORMAL = 2'd3;

	localparam logic [9:0] SRC_DIM_RST = 10'd512;

	// 255.0 in 16.16
	localparam int NORM_D = 255 * 65536;

endpackage

// ===== hdl/lbr_coord.sv =====
module lbr_coord import lbr_pkg::*; #(
	parameter int ATLAS_SIZE = 512,
	parameter int MAX_SOURCE_DIM = 512,
	localparam int AIW = $clog2(ATLAS_SIZE),
	localparam int XW = $clog2(MAX_SOURCE_DIM),
	localparam int EW = 1 + 2 * XW + 8
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           restart,
	input  cfg_t           cfg,
	output logic           ready,
	input  logic [AIW-1:0] rd_col,
	input  logic [AIW-1:0] rd_row,
	output logic [EW-1:0]  tab_x,
	output logic [EW-1:0]  tab_y
);

	localparam int SW = XW + 1;
	localparam int AW = AIW + 1;
	localparam int DENW = (SW > AW ? SW : AW) + 1;
	localparam int NUMW = SW + AW + 18;
	localparam int QW = SW + 17;
	localparam int CW = $clog2(NUMW + 2);

	typedef enum logic [7:0] {
		ST_FIT  = 8'b0000_0001,
		ST_XB   = 8'b0000_0010,
		ST_XS   = 8'b0000_0100,
		ST_SWX  = 8'b0000_1000,
		ST_YB   = 8'b0001_0000,
		ST_YS   = 8'b0010_0000,
		ST_SWY  = 8'b0100_0000,
		ST_DONE = 8'b1000_0000
	} st_t;

	st_t state_q, nxt_div;
	logic [CW-1:0] dcnt_q;
	logic [NUMW-1:0] dnum_q, dnum_ld;
	logic [DENW-1:0] drem_q, dden, rem_nx;
	logic [DENW:0] dt, dsub;
	logic dge, div_fin, axis_y, p_last, in_rng, rs_ge;
	logic [SW-1:0] w, h, maj, mnr, dim;
	logic [AW-1:0] fitw_q, fith_q, fit, off, fm;
	logic [QW-1:0] acc_q, stepq_q, sm, hi;
	logic [DENW-1:0] racc_q, stepr_q;
	logic [DENW:0] rs;
	logic [AIW-1:0] p_q;
	logic [XW-1:0] x0, x1;
	logic [SW-1:0] x0p1;
	logic [EW-1:0] ent;
	logic [EW-1:0] tabx_mem [ATLAS_SIZE];
	logic [EW-1:0] taby_mem [ATLAS_SIZE];
	logic [EW-1:0] tx_q, ty_q;

	always_comb begin
		if (cfg.width == '0)
			w = SW'(1);
		else if (32'(cfg.width) > MAX_SOURCE_DIM)
			w = SW'(MAX_SOURCE_DIM);
		else
			w = SW'(cfg.width);
		if (cfg.height == '0)
			h = SW'(1);
		else if (32'(cfg.height) > MAX_SOURCE_DIM)
			h = SW'(MAX_SOURCE_DIM);
		else
			h = SW'(cfg.height);
		maj = (w >= h) ? w : h;
		mnr = (w >= h) ? h : w;
	end

	assign axis_y = (state_q == ST_YB) || (state_q == ST_YS) || (state_q == ST_SWY);
	assign dim = axis_y ? h : w;
	assign fit = axis_y ? fith_q : fitw_q;
	assign off = (AW'(ATLAS_SIZE) - fit) >> 1;

	always_comb begin
		unique case (state_q)
			ST_FIT: begin
				dnum_ld = NUMW'(mnr) * NUMW'(2 * ATLAS_SIZE) + NUMW'(maj);
				dden = DENW'({maj, 1'b0});
				nxt_div = ST_XB;
			end
			ST_XB: begin
				dnum_ld = NUMW'(dim) << 16;
				dden = DENW'({fit, 1'b0});
				nxt_div = ST_XS;
			end
			ST_XS: begin
				dnum_ld = NUMW'(dim) << 17;
				dden = DENW'({fit, 1'b0});
				nxt_div = ST_SWX;
			end
			ST_YB: begin
				dnum_ld = NUMW'(dim) << 16;
				dden = DENW'({fit, 1'b0});
				nxt_div = ST_YS;
			end
			ST_YS: begin
				dnum_ld = NUMW'(dim) << 17;
				dden = DENW'({fit, 1'b0});
				nxt_div = ST_SWY;
			end
			default: begin
				dnum_ld = '0;
				dden = DENW'({fit, 1'b0});
				nxt_div = ST_DONE;
			end
		endcase
	end

	assign dt = {drem_q, dnum_q[NUMW-1]};
	assign dsub = dt - {1'b0, dden};
	assign dge = dt >= {1'b0, dden};
	assign rem_nx = dge ? dsub[DENW-1:0] : dt[DENW-1:0];
	assign div_fin = dcnt_q == CW'(NUMW + 1);
	assign fm = (dnum_q[AW-1:0] == '0) ? AW'(1) : dnum_q[AW-1:0];

	// sweep entry
	always_comb begin
		in_rng = (AW'(p_q) >= off) && (AW'(p_q) < off + fit);
		hi = QW'(dim - SW'(1)) << 16;
		sm = (acc_q < QW'(32768)) ? '0 : acc_q - QW'(32768);
		if (sm > hi)
			sm = hi;
		x0 = sm[16 +: XW];
		x0p1 = SW'(x0) + SW'(1);
		x1 = (x0p1 < dim) ? x0p1[XW-1:0] : XW'(dim - SW'(1));
		ent = {in_rng, x0, x1, sm[15:8]};
		rs = {1'b0, racc_q} + {1'b0, stepr_q};
		rs_ge = rs >= {1'b0, dden};
	end

	assign p_last = p_q == AIW'(ATLAS_SIZE - 1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_FIT;
			dcnt_q <= '0;
		end else if (restart) begin
			state_q <= ST_FIT;
			dcnt_q <= '0;
		end else begin
			unique case (state_q)
				ST_FIT, ST_XB, ST_XS, ST_YB, ST_YS: begin
					if (div_fin) begin
						dcnt_q <= '0;
						state_q <= nxt_div;
					end else begin
						dcnt_q <= dcnt_q + CW'(1);
					end
				end
				ST_SWX: begin
					if (p_last)
						state_q <= ST_YB;
				end
				ST_SWY: begin
					if (p_last)
						state_q <= ST_DONE;
				end
				ST_DONE: begin
					state_q <= ST_DONE;
				end
				default: begin
					state_q <= ST_FIT;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_FIT, ST_XB, ST_XS, ST_YB, ST_YS: begin
				if (dcnt_q == '0) begin
					dnum_q <= dnum_ld;
					drem_q <= '0;
				end else if (!div_fin) begin
					dnum_q <= {dnum_q[NUMW-2:0], dge};
					drem_q <= rem_nx;
				end else begin
					if (state_q == ST_FIT) begin
						if (w >= h) begin
							fitw_q <= AW'(ATLAS_SIZE);
							fith_q <= fm;
						end else begin
							fith_q <= AW'(ATLAS_SIZE);
							fitw_q <= fm;
						end
					end else if (state_q == ST_XB || state_q == ST_YB) begin
						acc_q <= QW'(dnum_q);
						racc_q <= drem_q;
					end else begin
						stepq_q <= QW'(dnum_q);
						stepr_q <= drem_q;
						p_q <= '0;
					end
				end
			end
			ST_SWX, ST_SWY: begin
				p_q <= p_q + AIW'(1);
				if (in_rng) begin
					if (rs_ge) begin
						racc_q <= DENW'(rs - {1'b0, dden});
						acc_q <= acc_q + stepq_q + QW'(1);
					end else begin
						racc_q <= rs[DENW-1:0];
						acc_q <= acc_q + stepq_q;
					end
				end
			end
			default: begin
				p_q <= p_q;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_SWX)
			tabx_mem[p_q] <= ent;
		tx_q <= tabx_mem[rd_col];
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_SWY)
			taby_mem[p_q] <= ent;
		ty_q <= taby_mem[rd_row];
	end

	assign tab_x = tx_q;
	assign tab_y = ty_q;
	assign ready = state_q == ST_DONE;

endmodule

// ===== hdl/lbr_front.sv =====
module lbr_front import lbr_pkg::*; #(
	parameter int ATLAS_SIZE = 512,
	parameter int MAX_SOURCE_DIM = 512,
	localparam int AIW = $clog2(ATLAS_SIZE),
	localparam int XW = $clog2(MAX_SOURCE_DIM),
	localparam int EW = 1 + 2 * XW + 8,
	localparam int QEW = 3 + 4 * XW + 16 + 32
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  in_item_t       item,
	output logic           busy,
	input  logic           setup_ready,
	input  logic           room,
	output logic [AIW-1:0] rd_col,
	output logic [AIW-1:0] rd_row,
	input  logic [EW-1:0]  tab_x,
	input  logic [EW-1:0]  tab_y,
	output logic           push,
	output logic [QEW-1:0] entry
);

	logic accept, valid_s1, col_ok_s1, row_ok_s1, ld_ok;
	in_item_t item_s1;
	logic tx_in, ty_in, in_area;
	logic [XW-1:0] tx0, tx1, ty0, ty1, x0, x1, y0, y1;
	logic [7:0] tfx, tfy;

	assign busy = !setup_ready || !room;
	assign accept = start && !busy;
	assign rd_col = AIW'(item.col);
	assign rd_row = AIW'(item.row);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else
			valid_s1 <= accept;
	end

	always_ff @(posedge clk) begin
		item_s1 <= item;
		col_ok_s1 <= 32'(item.col) < ATLAS_SIZE;
		row_ok_s1 <= 32'(item.row) < ATLAS_SIZE;
	end

	assign {tx_in, tx0, tx1, tfx} = tab_x;
	assign {ty_in, ty0, ty1, tfy} = tab_y;

	always_comb begin
		ld_ok = (32'(item_s1.col) < MAX_SOURCE_DIM) && (32'(item_s1.row) < MAX_SOURCE_DIM);
		in_area = col_ok_s1 && row_ok_s1 && tx_in && ty_in;
		if (item_s1.kind == KIND_LOAD) begin
			x0 = XW'(item_s1.col);
			y0 = XW'(item_s1.row);
			x1 = x0;
			y1 = y0;
		end else begin
			x0 = tx0;
			x1 = tx1;
			y0 = ty0;
			y1 = ty1;
		end
	end

	assign push = valid_s1;
	assign entry = {item_s1.kind, ld_ok, in_area, x0, x1, y0, y1, tfx, tfy,
		item_s1.alpha, item_s1.blue, item_s1.green, item_s1.red};

endmodule

// ===== hdl/lbr_fifo.sv =====
module lbr_fifo import lbr_pkg::*; #(
	parameter int W = 8
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	input  logic [W-1:0] din,
	input  logic         pop,
	output logic [W-1:0] dout,
	output logic         empty,
	output logic         room
);

	localparam int DEPTH = 4;
	localparam int PW = $clog2(DEPTH);

	logic [W-1:0] mem_q [DEPTH];
	logic [PW-1:0] wp_q, rp_q;
	logic [PW:0] cnt_q;

	assign empty = cnt_q == '0;
	assign room = cnt_q < (PW + 1)'(DEPTH - 1);
	assign dout = mem_q[rp_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push)
				wp_q <= wp_q + PW'(1);
			if (pop)
				rp_q <= rp_q + PW'(1);
			if (push && !pop)
				cnt_q <= cnt_q + (PW + 1)'(1);
			else if (!push && pop)
				cnt_q <= cnt_q - (PW + 1)'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wp_q] <= din;
	end

endmodule

// ===== hdl/lbr_back.sv =====
module lbr_back import lbr_pkg::*; #(
	parameter int MAX_SOURCE_DIM = 512,
	localparam int XW = $clog2(MAX_SOURCE_DIM),
	localparam int QEW = 3 + 4 * XW + 16 + 32
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           avail,
	input  logic [QEW-1:0] entry,
	output logic           pop,
	input  cfg_t           cfg,
	output logic           done,
	output out_item_t      result
);

	localparam int BAW = 2 * (XW - 1);
	localparam int BD = 1 << BAW;

	logic q_kind, q_ldok, q_in;
	logic [XW-1:0] q_x0, q_x1, q_y0, q_y1;
	logic [7:0] q_fx, q_fy;
	logic [31:0] q_tex;
	logic wr;
	logic [BAW-1:0] waddr;
	logic [31:0] bank_rd [2][2];

	logic valid_s2, in_s2, px0_s2, px1_s2, py0_s2, py1_s2;
	logic [7:0] fx_s2, fy_s2;
	logic [31:0] t00, t10, t01, t11;
	logic [7:0] c00 [4], c10 [4], c01 [4], c11 [4];

	logic valid_s3, in_s3;
	logic [7:0] fy_s3;
	logic [16:0] top_s3 [4], bot_s3 [4];

	logic valid_s4, in_s4;
	logic [24:0] s_s4 [4];

	logic valid_s5, in_s5, nrm_s5;
	logic [7:0] col_s5 [4];
	logic [14:0] z_s5 [2];
	logic neg_s5 [2];

	logic valid_s6, in_s6, nrm_s6;
	logic [7:0] col_s6 [4];
	logic [14:0] z_s6 [2];
	logic [7:0] e_s6 [2];
	logic neg_s6 [2];

	logic [7:0] nb [2];
	out_item_t res_q;
	logic done_q;

	assign {q_kind, q_ldok, q_in, q_x0, q_x1, q_y0, q_y1, q_fx, q_fy, q_tex} = entry;
	assign pop = avail;
	assign wr = avail && (q_kind == KIND_LOAD) && q_ldok;
	assign waddr = {q_y0[XW-1:1], q_x0[XW-1:1]};

	// store split by row and column parity: four taps, one read each
	for (genvar gy = 0; gy < 2; gy++) begin : g_row
		for (genvar gx = 0; gx < 2; gx++) begin : g_col
			logic [31:0] mem [BD];
			logic [XW-1:0] ry, rx;
			logic [BAW-1:0] raddr;
			assign ry = (q_y0[0] == 1'(gy)) ? q_y0 : q_y1;
			assign rx = (q_x0[0] == 1'(gx)) ? q_x0 : q_x1;
			assign raddr = {ry[XW-1:1], rx[XW-1:1]};
			always_ff @(posedge clk) begin
				if (wr && q_y0[0] == 1'(gy) && q_x0[0] == 1'(gx))
					mem[waddr] <= q_tex;
				bank_rd[gy][gx] <= mem[raddr];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
			valid_s6 <= 1'b0;
			done_q <= 1'b0;
		end else begin
			valid_s2 <= avail && (q_kind == KIND_REQ);
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
			valid_s5 <= valid_s4;
			valid_s6 <= valid_s5;
			done_q <= valid_s6;
		end
	end

	always_ff @(posedge clk) begin
		in_s2 <= q_in;
		px0_s2 <= q_x0[0];
		px1_s2 <= q_x1[0];
		py0_s2 <= q_y0[0];
		py1_s2 <= q_y1[0];
		fx_s2 <= q_fx;
		fy_s2 <= q_fy;
	end

	assign t00 = bank_rd[py0_s2][px0_s2];
	assign t10 = bank_rd[py0_s2][px1_s2];
	assign t01 = bank_rd[py1_s2][px0_s2];
	assign t11 = bank_rd[py1_s2][px1_s2];

	always_comb begin
		for (int c = 0; c < 4; c++) begin
			if (cfg.grey) begin
				c00[c] = (c == 3) ? 8'hFF : t00[7:0];
				c10[c] = (c == 3) ? 8'hFF : t10[7:0];
				c01[c] = (c == 3) ? 8'hFF : t01[7:0];
				c11[c] = (c == 3) ? 8'hFF : t11[7:0];
			end else begin
				c00[c] = t00[8*c +: 8];
				c10[c] = t10[8*c +: 8];
				c01[c] = t01[8*c +: 8];
				c11[c] = t11[8*c +: 8];
			end
		end
	end

	always_ff @(posedge clk) begin
		in_s3 <= in_s2;
		fy_s3 <= fy_s2;
		for (int c = 0; c < 4; c++) begin
			top_s3[c] <= 17'(c00[c]) * (17'd256 - 17'(fx_s2)) + 17'(c10[c]) * 17'(fx_s2);
			bot_s3[c] <= 17'(c01[c]) * (17'd256 - 17'(fx_s2)) + 17'(c11[c]) * 17'(fx_s2);
		end
	end

	always_ff @(posedge clk) begin
		in_s4 <= in_s3;
		for (int c = 0; c < 4; c++)
			s_s4[c] <= 25'(top_s3[c]) * (25'd256 - 25'(fy_s3)) + 25'(bot_s3[c]) * 25'(fy_s3);
	end

	// normal: q = floor((254*|2s-D| + D) / (2D)) = floor(((...) >> 17) / 255)
	always_ff @(posedge clk) begin : p_s5
		logic signed [27:0] sd;
		logic [24:0] m;
		logic [32:0] x;
		logic [24:0] rnd;
		in_s5 <= in_s4;
		nrm_s5 <= cfg.normal;
		for (int c = 0; c < 4; c++) begin
			rnd = s_s4[c] + 25'd32768;
			col_s5[c] <= rnd[23:16];
		end
		for (int c = 0; c < 2; c++) begin
			sd = $signed({2'b00, s_s4[c], 1'b0}) - 28'(NORM_D);
			m = sd[27] ? 25'(-sd) : 25'(sd);
			x = 33'(m) * 33'd254 + 33'(NORM_D);
			z_s5[c] <= x[31:17];
			neg_s5[c] <= sd[27];
		end
	end

	always_ff @(posedge clk) begin : p_s6
		logic [23:0] pr;
		in_s6 <= in_s5;
		nrm_s6 <= nrm_s5;
		col_s6 <= col_s5;
		for (int c = 0; c < 2; c++) begin
			pr = 24'(z_s5[c]) * 24'd257;
			e_s6[c] <= pr[23:16];
			z_s6[c] <= z_s5[c];
			neg_s6[c] <= neg_s5[c];
		end
	end

	always_comb begin : p_fix
		logic [15:0] r;
		logic [7:0] q;
		for (int c = 0; c < 2; c++) begin
			r = 16'(z_s6[c]) - 16'(e_s6[c]) * 16'd255;
			q = (r >= 16'd255) ? e_s6[c] + 8'd1 : e_s6[c];
			nb[c] = neg_s6[c] ? 8'(-q) : q;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_s6) begin
			res_q <= '0;
		end else if (nrm_s6) begin
			res_q.byte0 <= nb[0];
			res_q.byte1 <= nb[1];
			res_q.byte2 <= '0;
			res_q.byte3 <= '0;
			res_q.inside_res <= 1'b1;
		end else begin
			res_q.byte0 <= col_s6[0];
			res_q.byte1 <= col_s6[1];
			res_q.byte2 <= col_s6[2];
			res_q.byte3 <= col_s6[3];
			res_q.inside_res <= 1'b1;
		end
	end

	assign done = done_q;
	assign result = res_q;

endmodule

// ===== hdl/letterbox_bilinear_resampler_core.sv =====
// A request passes the front register, FIFO, store read, pipeline stages and result register.
// Throughput: one beat per clock while busy is low, loads and requests alike; loads give no result.
// After reset and after every register write, busy stays high while the coordinate tables are
// rebuilt: five 1-bit-per-cycle divisions and two atlas sweeps. Reset clears control and
// registers; the store is undefined.
// The result strobe cannot be stalled by the receiver.
module letterbox_bilinear_resampler_core import lbr_pkg::*; #(
	parameter int ATLAS_SIZE = 512,
	parameter int MAX_SOURCE_DIM = 512
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  in_item_t    item,
	output logic        done,
	output out_item_t   result,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	localparam int AIW = $clog2(ATLAS_SIZE);
	localparam int XW = $clog2(MAX_SOURCE_DIM);
	localparam int EW = 1 + 2 * XW + 8;
	localparam int QEW = 3 + 4 * XW + 16 + 32;

	cfg_t cfg_q;
	logic cfg_wr, setup_ready, room, push, empty, pop;
	logic [AIW-1:0] rd_col, rd_row;
	logic [EW-1:0] tab_x, tab_y;
	logic [QEW-1:0] f_entry, b_entry;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.width <= SRC_DIM_RST;
			cfg_q.height <= SRC_DIM_RST;
			cfg_q.grey <= 1'b0;
			cfg_q.normal <= 1'b0;
		end else if (cfg_wr) begin
			unique case (paddr[3:2])
				REG_SRC_W:  cfg_q.width <= pwdata[9:0];
				REG_SRC_H:  cfg_q.height <= pwdata[9:0];
				REG_GREY:   cfg_q.grey <= pwdata[0];
				REG_NORMAL: cfg_q.normal <= pwdata[0];
				default:    cfg_q <= cfg_q;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[3:2])
			REG_SRC_W:  prdata = {22'b0, cfg_q.width};
			REG_SRC_H:  prdata = {22'b0, cfg_q.height};
			REG_GREY:   prdata = {31'b0, cfg_q.grey};
			REG_NORMAL: prdata = {31'b0, cfg_q.normal};
			default:    prdata = '0;
		endcase
	end

	lbr_coord #(
		.ATLAS_SIZE(ATLAS_SIZE),
		.MAX_SOURCE_DIM(MAX_SOURCE_DIM)
	) u_coord (
		.clk(clk),
		.arst_n(arst_n),
		.restart(cfg_wr),
		.cfg(cfg_q),
		.ready(setup_ready),
		.rd_col(rd_col),
		.rd_row(rd_row),
		.tab_x(tab_x),
		.tab_y(tab_y)
	);

	lbr_front #(
		.ATLAS_SIZE(ATLAS_SIZE),
		.MAX_SOURCE_DIM(MAX_SOURCE_DIM)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.item(item),
		.busy(busy),
		.setup_ready(setup_ready),
		.room(room),
		.rd_col(rd_col),
		.rd_row(rd_row),
		.tab_x(tab_x),
		.tab_y(tab_y),
		.push(push),
		.entry(f_entry)
	);

	lbr_fifo #(
		.W(QEW)
	) u_fifo (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.din(f_entry),
		.pop(pop),
		.dout(b_entry),
		.empty(empty),
		.room(room)
	);

	lbr_back #(
		.MAX_SOURCE_DIM(MAX_SOURCE_DIM)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.avail(!empty),
		.entry(b_entry),
		.pop(pop),
		.cfg(cfg_q),
		.done(done),
		.result(result)
	);

endmodule
